/* src/fst_pkg.sv */
// ----------------------------------------------------------------------------
// fst_pkg
// Shared constants, codes and types for the stepper tone channel core.
// ----------------------------------------------------------------------------
package fst_pkg;

   // Number of stepper channels and width of the half-period and tick counters.
   localparam int CHANNELS    = 8;
   localparam int PERIOD_BITS = 16;

   // Channel index width, head position width, width of the result fields and widths of the request fields.
   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_BITS    = 8;
   localparam int OUT_BITS    = 8;
   localparam int FUNC_BITS   = 2;
   localparam int CHAN_BITS   = 3;

   localparam logic [CH_IDX_BITS-1:0] LAST_IDX = CH_IDX_BITS'(CHANNELS - 1);

   // Travel limit after reset.
   localparam logic [POS_BITS-1:0] TRAVEL_RESET = 8'd158;

   // Function codes of a request.
   localparam logic [FUNC_BITS-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_SET  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_HOME = 2'd2;

   // Queue between the front and the engine.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   // Classified operation carried through the queue.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_TICK,
      OP_SET,
      OP_HOME
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [CH_IDX_BITS-1:0]  chan;
      logic [PERIOD_BITS-1:0]  period;
   } cmd_type;

   // Queue status seen by the front and the engine.
   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SWEEP,
      ENG_DONE
   } eng_state_type;

   // Engine control decoded from the sequencer state.
   typedef struct packed {
      logic pop;
      logic sweep;
      logic apply;
      logic load;
   } eng_ctl_type;

endpackage

/* src/fst_front.sv */
// ----------------------------------------------------------------------------
// fst_front
// Request decoder: classifies each request and pushes it into the queue.
// ----------------------------------------------------------------------------
module fst_front
   import fst_pkg::*;
(
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FUNC_BITS-1:0]   req_func,
   input  logic [CHAN_BITS-1:0]   req_channel,
   input  logic [PERIOD_BITS-1:0] req_period_value,
   input  q_status_type           q_status,
   output logic                   push,
   output cmd_type                push_cmd
);

   logic in_range;

   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;
   assign in_range  = (32'(req_channel) < CHANNELS);

   always_comb begin
      push_cmd.chan   = CH_IDX_BITS'(req_channel);
      push_cmd.period = req_period_value;
      case (req_func)
         FUNC_TICK: push_cmd.op = OP_TICK;
         // A set request for a channel that does not exist changes nothing.
         FUNC_SET:  push_cmd.op = in_range ? OP_SET : OP_NONE;
         FUNC_HOME: push_cmd.op = OP_HOME;
         default:   push_cmd.op = OP_NONE;
      endcase
   end

endmodule

/* src/fst_queue.sv */
// ----------------------------------------------------------------------------
// fst_queue
// Short command queue that decouples the decoder from the engine.
// ----------------------------------------------------------------------------
module fst_queue
   import fst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output q_status_type q_status,
   output cmd_type      head_cmd
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_cmd       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/fst_engine.sv */
// ----------------------------------------------------------------------------
// fst_engine
// Channel engine: holds the channel state, sweeps one channel per cycle on a
// tick, applies set and home commands, and holds the response register.
// ----------------------------------------------------------------------------
module fst_engine
   import fst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  cmd_type              cmd,
   output logic                 cmd_pop,
   input  logic [POS_BITS-1:0]  travel_limit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_BITS-1:0]  rsp_step_levels,
   output logic [OUT_BITS-1:0]  rsp_direction_levels
);

   eng_state_type           state_ff, state_in;
   eng_ctl_type             ctl;
   logic [CH_IDX_BITS-1:0]  idx_ff, idx_in;

   logic [PERIOD_BITS-1:0]  period_ff [CHANNELS];
   logic [PERIOD_BITS-1:0]  period_in [CHANNELS];
   logic [PERIOD_BITS-1:0]  count_ff  [CHANNELS];
   logic [PERIOD_BITS-1:0]  count_in  [CHANNELS];
   logic [POS_BITS-1:0]     pos_ff    [CHANNELS];
   logic [POS_BITS-1:0]     pos_in    [CHANNELS];
   logic [CHANNELS-1:0]     step_ff, step_in;
   logic [CHANNELS-1:0]     dir_ff, dir_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]     rsp_step_ff, rsp_step_in;
   logic [OUT_BITS-1:0]     rsp_dir_ff, rsp_dir_in;

   logic                    out_free;
   logic [PERIOD_BITS-1:0]  cur_period, cur_count, count_inc;
   logic [POS_BITS-1:0]     cur_pos, limit, new_pos;
   logic                    cur_dir, new_dir, hit, active;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (cmd_valid && cmd.op == OP_TICK) begin
               state_in = ENG_SWEEP;
            end
         end
         ENG_SWEEP: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ENG_DONE;
            end
         end
         ENG_DONE: begin
            if (out_free) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      ctl = '0;
      case (state_ff)
         ENG_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_TICK) begin
                  ctl.pop = 1'b1;
               end else if (out_free) begin
                  ctl.pop   = 1'b1;
                  ctl.apply = 1'b1;
                  ctl.load  = 1'b1;
               end
            end
         end
         ENG_SWEEP: ctl.sweep = 1'b1;
         ENG_DONE:  ctl.load  = out_free;
         default:   ctl = '0;
      endcase
   end

   assign cmd_pop = ctl.pop;

   // Tick update of the channel under the sweep index.
   always_comb begin
      cur_period = period_ff[idx_ff];
      cur_count  = count_ff[idx_ff];
      cur_pos    = pos_ff[idx_ff];
      cur_dir    = dir_ff[idx_ff];
      active     = (cur_period != '0);
      count_inc  = cur_count + 1'b1;
      hit        = (count_inc >= cur_period);
      // A zero limit behaves as one, so the head still moves between zero and one.
      limit      = (travel_limit == '0) ? POS_BITS'(1) : travel_limit;
      if (cur_pos >= limit) begin
         new_dir = 1'b1;
      end else if (cur_pos == '0) begin
         new_dir = 1'b0;
      end else begin
         new_dir = cur_dir;
      end
      if (new_dir) begin
         new_pos = (cur_pos != '0) ? cur_pos - 1'b1 : cur_pos;
      end else begin
         new_pos = cur_pos + 1'b1;
      end
   end

   // Next values of the channel state and the response register.
   always_comb begin
      period_in    = period_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      dir_in       = dir_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_dir_in   = rsp_dir_ff;

      if (ctl.sweep) begin
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         if (active) begin
            if (hit) begin
               count_in[idx_ff] = '0;
               pos_in[idx_ff]   = new_pos;
               dir_in[idx_ff]   = new_dir;
               step_in[idx_ff]  = !step_ff[idx_ff];
            end else begin
               count_in[idx_ff] = count_inc;
            end
         end
      end

      if (ctl.apply) begin
         case (cmd.op)
            OP_SET: period_in[cmd.chan] = cmd.period;
            OP_HOME: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  period_in[c] = '0;
                  pos_in[c]    = '0;
               end
               step_in = '0;
               dir_in  = '0;
            end
            default: ;
         endcase
      end

      if (ctl.load) begin
         rsp_valid_in = 1'b1;
         // Home clears the levels in this same cycle, so report the cleared value.
         if (ctl.apply && cmd.op == OP_HOME) begin
            rsp_step_in = '0;
            rsp_dir_in  = '0;
         end else begin
            rsp_step_in = OUT_BITS'(step_ff);
            rsp_dir_in  = OUT_BITS'(dir_ff);
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         dir_ff       <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            period_ff[c] <= '0;
            count_ff[c]  <= '0;
            pos_ff[c]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         dir_ff       <= dir_in;
         period_ff    <= period_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_step_ff <= rsp_step_in;
      rsp_dir_ff  <= rsp_dir_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_step_levels      = rsp_step_ff;
   assign rsp_direction_levels = rsp_dir_ff;

endmodule

/* src/floppy_stepper_tone_channels_core.sv */
// ----------------------------------------------------------------------------
// floppy_stepper_tone_channels_core
// Eight stepper tone channels driven by tick, set-period and home requests.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                                   Moves
//   req_*     in         valid/ready, func, channel, period      one request
//   rsp_*     out        valid/ready, step/direction levels      one response
//   csr_*     in         valid/ready, travel_limit               limit write
//
// A set-period, home or unused request is applied and loaded into the response
// register when the engine pops it from the queue. A tick leaves the queue, the
// engine sweeps each channel in turn and then loads the response, so the engine
// is busy with it for the whole sweep.
// Reset is synchronous and clears all channel state; no clearing pass follows.
// The two-entry queue keeps requests flowing while a response is stalled, and
// the engine stalls only when it must load a response into a full register.
//
module floppy_stepper_tone_channels_core
   import fst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FUNC_BITS-1:0]   req_func,
   input  logic [CHAN_BITS-1:0]   req_channel,
   input  logic [PERIOD_BITS-1:0] req_period_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_BITS-1:0]    rsp_step_levels,
   output logic [OUT_BITS-1:0]    rsp_direction_levels,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [POS_BITS-1:0]    csr_travel_limit
);

   // The user must write the travel limit register only while the core is idle (the
   // core does not enforce this), so it needs no synchronization with the engine.
   logic [POS_BITS-1:0] travel_limit_ff, travel_limit_in;

   q_status_type q_status;
   logic         push;
   cmd_type      push_cmd;
   cmd_type      head_cmd;
   logic         pop;

   assign csr_ready       = 1'b1;
   assign travel_limit_in = (csr_valid && csr_ready) ? csr_travel_limit : travel_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         travel_limit_ff <= TRAVEL_RESET;
      end else begin
         travel_limit_ff <= travel_limit_in;
      end
   end

   // The front decodes each request and turns set requests for absent channels into no-ops.
   fst_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_channel      (req_channel),
      .req_period_value (req_period_value),
      .q_status         (q_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   fst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head_cmd (head_cmd)
   );

   // The engine owns all channel state and the response register.
   fst_engine u_engine (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (q_status.valid),
      .cmd                  (head_cmd),
      .cmd_pop              (pop),
      .travel_limit         (travel_limit_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_step_levels      (rsp_step_levels),
      .rsp_direction_levels (rsp_direction_levels)
   );

`ifndef ASSERT_OFF
   // The queue never takes a request while it is full.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("request pushed into a full queue");

   // The engine never pops a command that is not there.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("command popped from an empty queue");

   // A command popped this cycle frees a slot, so the queue cannot be full next.
   a_pop_frees: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> !q_status.full)
      else $error("queue still full after a pop");
`endif

endmodule

/* dv/tb_floppy_stepper_tone_channels_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_floppy_stepper_tone_channels_core
// Self-checking bench for the eight-channel stepper tone core.
//
// A queue-fed driver offers tick, set-period, home and unused requests under
// random idling. A monitor compares each response with the levels predicted
// when the request was accepted. The travel limit is rewritten between phases,
// and one phase holds the response side off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_floppy_stepper_tone_channels_core;
   import fst_pkg::*;

   // The fourth function code is unused; the core must echo the levels.
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_REQUESTS = 100;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES = 80;
   localparam int PRINT_LIMIT = 30;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [CHAN_BITS-1:0]   chan;
      logic [PERIOD_BITS-1:0] period;
   } request_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] steps;
      logic [OUT_BITS-1:0] dirs;
   } levels_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [FUNC_BITS-1:0]   req_func = FUNC_TICK;
   logic [CHAN_BITS-1:0]   req_channel = '0;
   logic [PERIOD_BITS-1:0] req_period_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [OUT_BITS-1:0]    rsp_step_levels;
   logic [OUT_BITS-1:0]    rsp_direction_levels;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [POS_BITS-1:0]    csr_travel_limit = TRAVEL_RESET;

   floppy_stepper_tone_channels_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_channel          (req_channel),
      .req_period_value     (req_period_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_step_levels      (rsp_step_levels),
      .rsp_direction_levels (rsp_direction_levels),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_travel_limit     (csr_travel_limit)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Channel state mirrored by the predictor.
   logic [PERIOD_BITS-1:0] half_period [CHANNELS];
   logic [PERIOD_BITS-1:0] tick_count [CHANNELS];
   logic [POS_BITS-1:0]    head_pos [CHANNELS];
   logic [CHANNELS-1:0]    step_bits = '0;
   logic [CHANNELS-1:0]    dir_bits = '0;
   logic [POS_BITS-1:0]    travel_limit = TRAVEL_RESET;

   request_type pending_requests [$];
   levels_type  expected_levels_q [$];
   request_type next_req;
   levels_type  want_levels;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int phase_num = -1;
   logic rsp_hold = 1'b0;

   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int head_steps = 0;
   int reversals = 0;

   initial begin
      for (int c = 0; c < CHANNELS; c++) begin
         half_period[c] = '0;
         tick_count[c] = '0;
         head_pos[c] = '0;
      end
   end

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] ERROR: %s", $time, msg);
   endtask

   // Moves one channel's head by one position and toggles its step level.
   function automatic void step_head(input int c);
      logic [POS_BITS-1:0] lim;
      lim = (travel_limit == '0) ? 8'd1 : travel_limit;
      if (head_pos[c] >= lim) begin
         if (!dir_bits[c])
            reversals++;
         dir_bits[c] = 1'b1;
      end else if (head_pos[c] == '0) begin
         dir_bits[c] = 1'b0;
      end
      if (dir_bits[c]) begin
         if (head_pos[c] != '0)
            head_pos[c] = head_pos[c] - 1'b1;
      end else begin
         head_pos[c] = head_pos[c] + 1'b1;
      end
      step_bits[c] = ~step_bits[c];
      head_steps++;
   endfunction

   // Applies one accepted request to the mirrored state and returns the levels.
   function automatic levels_type apply_request(input request_type r);
      levels_type lv;
      int c;
      case (r.func)
         FUNC_TICK: begin
            for (c = 0; c < CHANNELS; c++) begin
               if (half_period[c] != '0) begin
                  tick_count[c] = tick_count[c] + 1'b1;
                  if (tick_count[c] >= half_period[c]) begin
                     step_head(c);
                     tick_count[c] = '0;
                  end
               end
            end
         end
         FUNC_SET: begin
            if (int'(r.chan) < CHANNELS)
               half_period[r.chan] = r.period;
         end
         FUNC_HOME: begin
            // Tick counters survive a home request.
            for (c = 0; c < CHANNELS; c++) begin
               half_period[c] = '0;
               head_pos[c] = '0;
            end
            step_bits = '0;
            dir_bits = '0;
         end
         default: begin
         end
      endcase
      lv.steps = OUT_BITS'(step_bits);
      lv.dirs = OUT_BITS'(dir_bits);
      return lv;
   endfunction

   // Request driver: valid stays up with a stable payload until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_levels_q.push_back(apply_request('{req_func, req_channel,
                                                        req_period_value}));
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_func <= next_req.func;
               req_channel <= next_req.chan;
               req_period_value <= next_req.period;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and ready generator.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels_q.size() == 0) begin
               log_error($sformatf("unexpected response: step %02h dir %02h",
                                   rsp_step_levels, rsp_direction_levels));
            end else begin
               want_levels = expected_levels_q.pop_front();
               if (rsp_step_levels !== want_levels.steps)
                  log_error($sformatf("response %0d step levels %02h, want %02h",
                                      responses_checked, rsp_step_levels,
                                      want_levels.steps));
               if (rsp_direction_levels !== want_levels.dirs)
                  log_error($sformatf("response %0d direction levels %02h, want %02h",
                                      responses_checked, rsp_direction_levels,
                                      want_levels.dirs));
               responses_checked++;
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long response stall in the third phase so the core backs up its input.
   initial begin
      wait (phase_num == 2);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic queue_request(input logic [FUNC_BITS-1:0] f,
                                input logic [CHAN_BITS-1:0] ch,
                                input logic [PERIOD_BITS-1:0] pv);
      pending_requests.push_back('{f, ch, pv});
   endtask

   // Mostly ticks and short periods so that heads travel and reverse.
   function automatic request_type random_request();
      request_type r;
      int roll;
      int pick;
      r.chan = CHAN_BITS'($urandom_range(7));
      r.period = PERIOD_BITS'($urandom);
      roll = $urandom_range(99);
      if (roll < 55) begin
         r.func = FUNC_TICK;
      end else if (roll < 87) begin
         r.func = FUNC_SET;
         pick = $urandom_range(9);
         if (pick <= 5)
            r.period = PERIOD_BITS'($urandom_range(1, 4));
         else if (pick == 6)
            r.period = '0;
         else if (pick == 7)
            r.period = '1;
      end else if (roll < 94) begin
         r.func = FUNC_UNUSED;
      end else begin
         r.func = FUNC_HOME;
      end
      return r;
   endfunction

   task automatic write_travel_limit(input logic [POS_BITS-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_travel_limit <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      travel_limit = v;
   endtask

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_valid || expected_levels_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [POS_BITS-1:0] limit_plan [RANDOM_PHASES];
      int ph;
      int n;
      limit_plan = '{8'd3, 8'd255, 8'd0, 8'd1, 8'd5, 8'd158};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed phase with a short travel so reversals show up quickly.
      phase_num = 0;
      send_idle_pct = 17;
      recv_idle_pct = 51;
      write_travel_limit(8'd2);
      queue_request(FUNC_UNUSED, 3'd7, 16'hFFFF);
      queue_request(FUNC_TICK, 3'd0, 16'h0000);
      queue_request(FUNC_SET, 3'd0, 16'd1);
      queue_request(FUNC_SET, 3'd7, 16'hFFFF);
      queue_request(FUNC_SET, 3'd3, 16'd2);
      queue_request(FUNC_SET, 3'd5, 16'd3);
      repeat (6) queue_request(FUNC_TICK, 3'd7, 16'hFFFF);
      // Lower a period below a count that is already running.
      queue_request(FUNC_SET, 3'd1, 16'd4);
      repeat (2) queue_request(FUNC_TICK, 3'd0, 16'h0000);
      queue_request(FUNC_SET, 3'd1, 16'd1);
      queue_request(FUNC_TICK, 3'd2, 16'h5555);
      queue_request(FUNC_SET, 3'd3, 16'd0);
      queue_request(FUNC_TICK, 3'd5, 16'hAAAA);
      queue_request(FUNC_UNUSED, 3'd0, 16'h0000);
      queue_request(FUNC_HOME, 3'd6, 16'h1234);
      queue_request(FUNC_TICK, 3'd1, 16'h0001);
      queue_request(FUNC_SET, 3'd6, 16'd1);
      queue_request(FUNC_TICK, 3'd0, 16'h0000);
      wait_until_drained();

      for (ph = 1; ph <= RANDOM_PHASES; ph++) begin
         if (ph <= 2) begin
            send_idle_pct = 17;
            recv_idle_pct = 51;
         end else if (ph <= 4) begin
            send_idle_pct = 51;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_travel_limit(limit_plan[ph-1]);
         for (n = 0; n < PHASE_REQUESTS; n++)
            pending_requests.push_back(random_request());
         phase_num = ph;
         wait_until_drained();
      end

      $display("Run covered %0d requests and %0d checked responses over %0d travel limits.",
               requests_sent, responses_checked, RANDOM_PHASES + 1);
      $display("Predicted %0d head steps and %0d direction reversals.",
               head_steps, reversals);
      if (error_count == 0 && expected_levels_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Timeout with %0d responses still outstanding.", expected_levels_q.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
